FILE: rtl/coordinate_line_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Coordinate line parser assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_LINE_PARSER_TOP_ASSERT_SVH
`define COORDINATE_LINE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define CLP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coordinate line parser check failed");
// Next-cycle implication, checked out of reset
`define CLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coordinate line parser check failed");
`else
`define CLP_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/clp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate line parser package
// Word types, character codes, status and state encodings.
// ----------------------------------------------------------------------------
package clp_pkg;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam int NUM_VALUES = 4;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BLANK     = 2'd1,
      ST_NOT_COORD = 2'd2,
      ST_MALFORMED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_BETWEEN = 2'd0,
      PH_SIGN    = 2'd1,
      PH_DIGITS  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      FC_NONE  = 2'd0,
      FC_CAND  = 2'd1,
      FC_OTHER = 2'd2
   } class_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       edge_line;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               line_is_edge;
      logic signed [63:0] first_x;
      logic signed [63:0] first_y;
      logic signed [63:0] second_x;
      logic signed [63:0] second_y;
   } rsp_type;

   typedef struct packed {
      logic [2:0] numbers_done;
      logic       bad_line;
   } line_stat_type;

endpackage

FILE: rtl/coordinate_line_parser_top.sv
`timescale 1ns / 1ps
// Path: input register, then the core builds the result word into the output register.
// Throughput: one byte word per cycle; the only stall is a newline meeting a full
//   result register that the consumer does not drain in that cycle.
// Reset: synchronous, active high; clears the valids and the line state.
// The multiply-by-ten accumulate between the input and magnitude registers sets the clock.
// ----------------------------------------------------------------------------
// Coordinate line parser top
// Parses text lines into two or four signed 64-bit integers or a status.
// ----------------------------------------------------------------------------
`include "coordinate_line_parser_top_assert.svh"

module coordinate_line_parser_top
   import clp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic          s1_valid;
   req_type       s1_data;
   logic          s1_take;
   logic          out_free;
   logic          rsp_load;
   rsp_type       rsp_next;
   line_stat_type line_stat;
   logic          second_zero;
   logic          all_zero;
   logic          line_clear;

   // hold a newline while the result register is occupied and not being drained
   assign s1_take = s1_valid && (s1_data.ch != CH_NEWLINE || out_free);

   clp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .s1_take   (s1_take)
   );

   clp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (s1_take),
      .in_data   (s1_data),
      .rsp_load  (rsp_load),
      .rsp_next  (rsp_next),
      .line_stat (line_stat)
   );

   clp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_next),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign second_zero = rsp_data.second_x == 64'd0 && rsp_data.second_y == 64'd0;
   assign all_zero    = second_zero && rsp_data.first_x == 64'd0 &&
                        rsp_data.first_y == 64'd0;
   assign line_clear  = line_stat.numbers_done == 3'd0 && !line_stat.bad_line;

   `CLP_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, all_zero)
   `CLP_ASSERT_SAME(a_point_zero, clock, reset, rsp_valid && !rsp_data.line_is_edge, second_zero)
   `CLP_ASSERT_SAME(a_count_range, clock, reset, 1'b1, line_stat.numbers_done <= 3'd4)
   `CLP_ASSERT_NEXT(a_line_cleared, clock, reset, rsp_load, line_clear)

endmodule

FILE: rtl/clp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate line parser input stage
// Registers one incoming byte word and hands it to the parser core.
// ----------------------------------------------------------------------------
module clp_in_stage
   import clp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    s1_valid,
   output req_type s1_data,
   input  logic    s1_take
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    load;

   assign req_ready = !valid_ff || s1_take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (s1_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign s1_valid = valid_ff;
   assign s1_data  = data_ff;

endmodule

FILE: rtl/clp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate line parser core
// Per-byte line state update and result build at the newline.
// ----------------------------------------------------------------------------
module clp_core
   import clp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  req_type       in_data,
   output logic          rsp_load,
   output rsp_type       rsp_next,
   output line_stat_type line_stat
);

   phase_type   phase_ff, phase_in;
   class_type   class_ff, class_in;
   logic [2:0]  done_ff, done_in;
   logic        neg_ff, neg_in;
   logic        bad_ff, bad_in;
   logic [63:0] mag_ff, mag_in;
   logic [63:0] vals_ff [NUM_VALUES];
   logic [63:0] vals_in [NUM_VALUES];

   logic        is_nl, is_blank, is_digit, is_sign, cand;
   logic [63:0] mag_base;
   logic        neg_base;
   logic [67:0] prod, limit;
   logic        ovf;
   logic [63:0] fin_val;
   logic [2:0]  done_eff, want;
   logic        fin, sign_open;
   logic [63:0] out_v [NUM_VALUES];
   status_type  status;

   assign is_nl    = in_data.ch == CH_NEWLINE;
   assign is_blank = in_data.ch == CH_SPACE || in_data.ch == CH_TAB ||
                     in_data.ch == CH_CR || in_data.ch == CH_VTAB ||
                     in_data.ch == CH_FFEED;
   assign is_digit = in_data.ch >= CH_ZERO && in_data.ch <= CH_NINE;
   assign is_sign  = in_data.ch == CH_PLUS || in_data.ch == CH_MINUS;
   assign cand     = class_ff == FC_CAND && !bad_ff;

   // a digit after a gap starts a fresh positive number
   assign mag_base = (phase_ff == PH_BETWEEN) ? 64'd0 : mag_ff;
   assign neg_base = (phase_ff == PH_BETWEEN) ? 1'b0 : neg_ff;
   assign prod     = ({4'd0, mag_base} << 3) + ({4'd0, mag_base} << 1)
                     + {64'd0, in_data.ch[3:0]};
   assign limit    = neg_base ? {5'd0, 1'b1, 62'd0} : {5'd0, 1'b0, {62{1'b1}}};
   assign ovf      = prod > {limit[66:0], limit[0]};
   assign fin_val  = neg_ff ? (64'd0 - mag_ff) : mag_ff;
   assign done_eff = done_ff + {2'd0, phase_ff == PH_DIGITS};
   assign want     = in_data.edge_line ? 3'd4 : 3'd2;
   assign fin       = cand && phase_ff == PH_DIGITS;
   assign sign_open = cand && phase_ff == PH_SIGN;

   always_comb begin
      for (int k = 0; k < NUM_VALUES; k++) begin
         out_v[k] = (fin && !done_ff[2] && done_ff[1:0] == 2'(k)) ? fin_val
                                                                  : vals_ff[k];
      end
      if (class_ff == FC_NONE) begin
         status = ST_BLANK;
      end else if (class_ff == FC_OTHER) begin
         status = ST_NOT_COORD;
      end else if (bad_ff || sign_open || done_eff != want) begin
         status = ST_MALFORMED;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      class_in = class_ff;
      done_in  = done_ff;
      neg_in   = neg_ff;
      bad_in   = bad_ff;
      mag_in   = mag_ff;
      for (int k = 0; k < NUM_VALUES; k++) begin
         vals_in[k] = vals_ff[k];
      end
      rsp_load = 1'b0;

      rsp_next.status       = status;
      rsp_next.line_is_edge = in_data.edge_line;
      rsp_next.first_x      = (status == ST_OK) ? out_v[0] : 64'd0;
      rsp_next.first_y      = (status == ST_OK) ? out_v[1] : 64'd0;
      rsp_next.second_x     = (status == ST_OK && in_data.edge_line) ? out_v[2] : 64'd0;
      rsp_next.second_y     = (status == ST_OK && in_data.edge_line) ? out_v[3] : 64'd0;

      if (go) begin
         if (is_nl) begin
            rsp_load = 1'b1;
            phase_in = PH_BETWEEN;
            class_in = FC_NONE;
            done_in  = 3'd0;
            neg_in   = 1'b0;
            bad_in   = 1'b0;
         end else if (is_blank) begin
            if (sign_open) begin
               bad_in = 1'b1;
            end else if (fin) begin
               vals_in[done_ff[1:0]] = fin_val;
               done_in  = done_eff;
               phase_in = PH_BETWEEN;
            end
         end else begin
            if (class_ff == FC_NONE) begin
               class_in = (is_digit || is_sign) ? FC_CAND : FC_OTHER;
            end
            // first byte of a candidate line, or any byte of a good one
            if ((class_ff == FC_NONE && (is_digit || is_sign)) || cand) begin
               if (is_digit) begin
                  if ((phase_ff == PH_BETWEEN && done_ff[2]) || ovf) begin
                     bad_in = 1'b1;
                  end else begin
                     mag_in   = prod[63:0];
                     neg_in   = neg_base;
                     phase_in = PH_DIGITS;
                  end
               end else if (is_sign) begin
                  if (phase_ff == PH_SIGN) begin
                     bad_in = 1'b1;
                  end else begin
                     if (phase_ff == PH_DIGITS) begin
                        vals_in[done_ff[1:0]] = fin_val;
                        done_in  = done_eff;
                        phase_in = PH_BETWEEN;
                     end
                     if (done_eff[2]) begin
                        bad_in = 1'b1;
                     end else begin
                        neg_in   = in_data.ch == CH_MINUS;
                        mag_in   = 64'd0;
                        phase_in = PH_SIGN;
                     end
                  end
               end else begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         class_ff <= FC_NONE;
         done_ff  <= 3'd0;
         neg_ff   <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         done_ff  <= done_in;
         neg_ff   <= neg_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      for (int k = 0; k < NUM_VALUES; k++) begin
         vals_ff[k] <= vals_in[k];
      end
   end

   assign line_stat.numbers_done = done_ff;
   assign line_stat.bad_line     = bad_ff;

endmodule

FILE: rtl/clp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate line parser output stage
// Holds one finished result word until the consumer takes it.
// ----------------------------------------------------------------------------
module clp_out_stage
   import clp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate line parser testbench
// Sends text lines one byte word at a time and predicts each line record.
// Directed lines cover blanks, extremes, malformed forms and non-coordinate
// lines. A burst against a long output stall follows, then random lines.
// ----------------------------------------------------------------------------
module tb_top
   import clp_pkg::*;
();

   typedef logic [7:0] byte_queue_type[$];

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          MAX_PRINTS   = 40;
   localparam logic [63:0] POS_LIMIT    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT    = 64'h8000_0000_0000_0000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   coordinate_line_parser_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // line state of the predictor
   phase_type   ln_phase;
   class_type   ln_class;
   logic [2:0]  ln_count;
   logic        ln_neg;
   logic [63:0] ln_mag;
   logic [63:0] ln_vals [4];
   logic        ln_bad;

   rsp_type        expected_records[$];
   byte_queue_type line_buf;

   int  mismatch_count = 0;
   int  words_sent = 0;
   int  lines_sent = 0;
   int  status_tally [4] = '{0, 0, 0, 0};
   int  cycle_count = 0;
   int  hold_cycles = 0;
   bit  send_gaps_on = 1;
   bit  take_gaps_on = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d records outstanding", cycle_count,
                  expected_records.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTS)
         $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic void clear_line();
      ln_phase = PH_BETWEEN;
      ln_class = FC_NONE;
      ln_count = 3'd0;
      ln_neg   = 1'b0;
      ln_mag   = '0;
      ln_bad   = 1'b0;
      foreach (ln_vals[k]) ln_vals[k] = '0;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void close_number();
      if (ln_count < 3'd4)
         ln_vals[ln_count[1:0]] = ln_neg ? -ln_mag : ln_mag;
      ln_count++;
      ln_phase = PH_BETWEEN;
   endfunction

   function automatic void open_number(input logic neg);
      if (ln_count >= 3'd4) begin
         ln_bad = 1'b1;
         return;
      end
      ln_neg   = neg;
      ln_mag   = '0;
      ln_phase = PH_SIGN;
   endfunction

   function automatic void parse_byte(input req_type w);
      logic [7:0]  c;
      logic [2:0]  want;
      logic [63:0] d;
      logic [63:0] lim;
      status_type  st;
      rsp_type     rec;
      c    = w.ch;
      want = w.edge_line ? 3'd4 : 3'd2;
      if (c != CH_NEWLINE) begin
         if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VTAB || c == CH_FFEED) begin
            if (ln_class == FC_CAND && !ln_bad) begin
               if (ln_phase == PH_SIGN)
                  ln_bad = 1'b1;
               else if (ln_phase == PH_DIGITS)
                  close_number();
            end
            return;
         end
         // first non-blank byte decides the line class
         if (ln_class == FC_NONE)
            ln_class = (is_digit(c) || c == CH_PLUS || c == CH_MINUS) ? FC_CAND : FC_OTHER;
         if (ln_class != FC_CAND || ln_bad)
            return;
         if (is_digit(c)) begin
            if (ln_phase == PH_BETWEEN)
               open_number(1'b0);
            if (!ln_bad) begin
               d   = {56'd0, c - CH_ZERO};
               lim = ln_neg ? NEG_LIMIT : POS_LIMIT;
               if (ln_mag > (lim - d) / 64'd10) begin
                  ln_bad = 1'b1;
               end else begin
                  ln_mag   = ln_mag * 64'd10 + d;
                  ln_phase = PH_DIGITS;
               end
            end
         end else if (c == CH_PLUS || c == CH_MINUS) begin
            if (ln_phase == PH_SIGN) begin
               ln_bad = 1'b1;
            end else begin
               if (ln_phase == PH_DIGITS)
                  close_number();
               open_number(c == CH_MINUS);
            end
         end else begin
            ln_bad = 1'b1;
         end
         return;
      end

      if (ln_class == FC_CAND && !ln_bad) begin
         if (ln_phase == PH_SIGN)
            ln_bad = 1'b1;
         else if (ln_phase == PH_DIGITS)
            close_number();
      end
      if (ln_class == FC_NONE)
         st = ST_BLANK;
      else if (ln_class == FC_OTHER)
         st = ST_NOT_COORD;
      else if (ln_bad || ln_count != want)
         st = ST_MALFORMED;
      else
         st = ST_OK;
      rec.status       = st;
      rec.line_is_edge = w.edge_line;
      rec.first_x      = (st == ST_OK) ? ln_vals[0] : '0;
      rec.first_y      = (st == ST_OK) ? ln_vals[1] : '0;
      rec.second_x     = (st == ST_OK && w.edge_line) ? ln_vals[2] : '0;
      rec.second_y     = (st == ST_OK && w.edge_line) ? ln_vals[3] : '0;
      expected_records = {expected_records, rec};
      clear_line();
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin : check_records
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            report_mismatch("line record with none expected");
         end else begin
            due = expected_records[0];
            expected_records.delete(0);
            status_tally[due.status]++;
            check_field("status", 64'(rsp_data.status), 64'(due.status));
            check_field("line_is_edge", 64'(rsp_data.line_is_edge), 64'(due.line_is_edge));
            check_field("first_x", rsp_data.first_x, due.first_x);
            check_field("first_y", rsp_data.first_y, due.first_y);
            check_field("second_x", rsp_data.second_x, due.second_x);
            check_field("second_y", rsp_data.second_y, due.second_y);
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   initial begin : take_records
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = take_gaps_on ? $urandom_range(0, 12) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && hold_cycles == 0);
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic send_word(input req_type w);
      int gap;
      gap = send_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!(req_valid && req_ready));
      parse_byte(w);
      words_sent++;
   endtask

   // edge_line only matters on the newline; toggle it freely elsewhere
   task automatic send_line(input byte_queue_type text, input logic edge_bit);
      req_type w;
      foreach (text[i]) begin
         w.ch        = text[i];
         w.edge_line = 1'($urandom_range(0, 1));
         send_word(w);
      end
      w.ch        = CH_NEWLINE;
      w.edge_line = edge_bit;
      send_word(w);
      lines_sent++;
   endtask

   function automatic byte_queue_type text_bytes(input string s);
      byte_queue_type q;
      foreach (s[i]) q = {q, s[i]};
      return q;
   endfunction

   // ---------------------------------------------------------------- line builder
   function automatic void append_byte(input logic [7:0] b);
      line_buf = {line_buf, b};
   endfunction

   function automatic void push_blanks(input int unsigned n);
      logic [7:0] blank_set [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_VTAB, CH_FFEED};
      repeat (n) append_byte(blank_set[$urandom_range(0, 4)]);
   endfunction

   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CH_NEWLINE) ? (b ^ 8'h80) : b;
   endfunction

   function automatic void push_number(input bit too_big);
      logic [63:0]  lim;
      logic [63:0]  mag;
      int unsigned  sign_kind;
      int unsigned  pick;
      string        digits;
      sign_kind = $urandom_range(0, 2);
      lim  = (sign_kind == 2) ? NEG_LIMIT : POS_LIMIT;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         mag = 64'($urandom_range(0, 999));
      else if (pick < 8)
         mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      else if (pick == 8)
         mag = lim;
      else
         mag = lim - 64'($urandom_range(0, 9));
      if (too_big)
         mag = lim + 64'd1 + 64'($urandom_range(0, 999));
      else if (mag > lim)
         mag = {1'b0, mag[62:0]};
      // an unsigned number needs a blank to split it from the one before
      if (line_buf.size() != 0 && (sign_kind == 0 || $urandom_range(0, 2) == 0))
         push_blanks($urandom_range(1, 3));
      if (sign_kind == 1)
         append_byte(CH_PLUS);
      else if (sign_kind == 2)
         append_byte(CH_MINUS);
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) append_byte(CH_ZERO);
      digits = $sformatf("%0d", mag);
      if (too_big && $urandom_range(0, 3) == 0)
         digits = {digits, "00"};
      foreach (digits[i]) append_byte(digits[i]);
   endfunction

   function automatic logic build_random_line();
      logic        edge_bit;
      int unsigned kind;
      int unsigned want;
      int unsigned count;
      int unsigned pos;
      int          bad_idx;
      line_buf.delete();
      edge_bit = 1'($urandom_range(0, 1));
      want     = edge_bit ? 4 : 2;
      kind     = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
         push_blanks($urandom_range(1, 3));
      if (kind < 88) begin
         count   = (kind >= 60 && kind < 70) ? $urandom_range(0, 5) : want;
         bad_idx = (kind >= 80) ? $urandom_range(0, count - 1) : -1;
         for (int k = 0; k < count; k++)
            push_number(k == bad_idx);
         // replace a byte of a well-formed line, or insert a sign, at one spot
         if (kind >= 70 && kind < 80 && line_buf.size() != 0) begin
            pos = $urandom_range(0, line_buf.size() - 1);
            if ($urandom_range(0, 1))
               line_buf[pos] = stray_byte();
            else
               line_buf.insert(pos, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
         end
         if ($urandom_range(0, 3) == 0)
            push_blanks($urandom_range(1, 2));
      end else if (kind < 95) begin
         repeat ($urandom_range(0, 16)) append_byte(stray_byte());
      end else begin
         append_byte(8'h61 + 8'($urandom_range(0, 25)));
         repeat (want) push_number(1'b0);
      end
      return edge_bit;
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_blank_lines();
      byte_queue_type empty;
      send_line(empty, 1'b0);
      send_line('{CH_SPACE, CH_TAB, CH_CR, CH_VTAB, CH_FFEED}, 1'b1);
   endtask

   task automatic test_good_lines();
      send_line(text_bytes("1 2"), 1'b0);
      send_line(text_bytes("-9223372036854775808 9223372036854775807"), 1'b0);
      send_line(text_bytes("+9223372036854775807-9223372036854775808+0-0"), 1'b1);
      send_line({CH_SPACE, CH_SPACE, text_bytes("0009"), CH_TAB, text_bytes("-90 ")}, 1'b0);
      send_line(text_bytes("1-2+3-4"), 1'b1);
   endtask

   task automatic test_malformed_lines();
      send_line(text_bytes("9223372036854775808 0"), 1'b0);
      send_line(text_bytes("-9223372036854775809 0"), 1'b0);
      send_line(text_bytes("1 2 3"), 1'b0);
      send_line(text_bytes("1 2 3 4 5"), 1'b1);
      send_line(text_bytes("1 2"), 1'b1);
      send_line(text_bytes("- 1 2"), 1'b0);
      send_line(text_bytes("+-1 2"), 1'b0);
      send_line(text_bytes("1 2 -"), 1'b0);
      send_line(text_bytes("1 x2"), 1'b0);
      send_line(text_bytes("+a 1"), 1'b0);
      send_line({text_bytes("1 2"), 8'hFF}, 1'b0);
   endtask

   task automatic test_other_lines();
      send_line(text_bytes("abc 1 2"), 1'b0);
      send_line(text_bytes(" #1 2 3 4"), 1'b1);
      send_line('{8'hFF, CH_ZERO}, 1'b0);
      send_line('{8'h00, CH_NINE, 8'h80}, 1'b1);
   endtask

   // stall the output long enough that the input backs up behind it
   task automatic test_stalled_output();
      send_gaps_on = 0;
      hold_cycles  = 250;
      repeat (12) send_line(text_bytes("7 -8"), 1'b0);
      send_gaps_on = 1;
   endtask

   task automatic test_random_lines();
      logic edge_bit;
      int   start_words;
      start_words = words_sent;
      while (words_sent - start_words < 900) begin
         if ($urandom_range(0, 4) == 0) send_gaps_on = !send_gaps_on;
         if ($urandom_range(0, 4) == 0) take_gaps_on = !take_gaps_on;
         edge_bit = build_random_line();
         send_line(line_buf, edge_bit);
      end
      send_gaps_on = 1;
      take_gaps_on = 1;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      clear_line();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_blank_lines();
      test_good_lines();
      test_malformed_lines();
      test_other_lines();
      test_stalled_output();
      test_random_lines();

      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_records.size() != 0)
         report_mismatch($sformatf("%0d line records never arrived", expected_records.size()));

      $display("sent %0d lines in %0d byte words, with idle gaps and one long output stall",
               lines_sent, words_sent);
      $display("line records: %0d ok, %0d blank, %0d not coordinate, %0d malformed",
               status_tally[ST_OK], status_tally[ST_BLANK], status_tally[ST_NOT_COORD],
               status_tally[ST_MALFORMED]);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
